>>> sv/tgarle_pkg.sv
// shared types, constants and register codes for the tga run-length pixel decoder
// no dependencies; compiled first
package tgarle_pkg;

  localparam int MAP_ENTRIES_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_KIND  = 3'd0,
    REG_RLE_ON      = 3'd1,
    REG_PIXEL_BYTES = 3'd2,
    REG_MAP_START   = 3'd3,
    REG_MAP_DEPTH   = 3'd4
  } cfg_reg_t;

  // image kinds
  localparam logic [1:0] KIND_CMAP = 2'd0;
  localparam logic [1:0] KIND_TRUE = 2'd1;
  localparam logic [1:0] KIND_GREY = 2'd2;

  // colour map entry formats
  localparam logic [1:0] DEPTH_15 = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;
  localparam logic [15:0] MASK_RED     = 16'h7c00;
  localparam logic [15:0] MASK_GREEN   = 16'h03e0;
  localparam logic [15:0] MASK_BLUE    = 16'h001f;
  localparam logic [15:0] MASK_ATTR    = 16'h8000;

  // completed pixel from the byte assembler
  typedef struct packed {
    logic        done;
    logic [31:0] pix;
    logic [7:0]  rep;
  } asm_t;

endpackage

>>> sv/tgarle_if.sv
// beat channels of the tga run-length pixel decoder: input, result and configuration
// depends on tgarle_pkg
interface tgarle_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic [7:0]  map_index;
  logic [31:0] map_bytes;

  modport source (output valid, action, data_byte, map_index, map_bytes, input ready);
  modport sink   (input valid, action, data_byte, map_index, map_bytes, output ready);
endinterface

interface tgarle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic [7:0]  repeat_res;
  logic        bad_index;

  modport source (output valid, pixel, repeat_res, bad_index, input ready);
  modport sink   (input valid, pixel, repeat_res, bad_index, output ready);
endinterface

interface tgarle_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tgarle_pkg::CFG_IDX_W-1:0]    index;
  logic [tgarle_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tgarle_assemble.sv
// packet header parsing and pixel byte assembly for the tga run-length decoder
// depends on tgarle_pkg
module tgarle_assemble (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              rle_on,
  input  logic [2:0]        pixel_bytes,
  output tgarle_pkg::asm_t  res
);
  import tgarle_pkg::*;

  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [23:0] partial_pixel, partial_pixel_next;
  logic [2:0]  size;
  logic        header;

  always_comb begin
    case (pixel_bytes)
      3'd0:    size = 3'd1;
      3'd1,
      3'd2,
      3'd3,
      3'd4:    size = pixel_bytes;
      default: size = 3'd4;
    endcase
  end

  assign header = rle_on && (packet_left == 8'd0) && (byte_position == 2'd0);

  always_comb begin
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    byte_position_next = byte_position;
    partial_pixel_next = partial_pixel;
    res.done = 1'b0;
    res.rep  = 8'd1;
    case (size)
      3'd1:    res.pix = {24'd0, data_byte};
      3'd2:    res.pix = {16'd0, data_byte, partial_pixel[7:0]};
      3'd3:    res.pix = ALPHA_OPAQUE | {8'd0, partial_pixel[15:0], data_byte};
      default: res.pix = {data_byte, partial_pixel};
    endcase
    if (header) begin
      packet_is_run_next = data_byte[7];
      packet_left_next   = data_byte[7] ? (data_byte - 8'd127) : (data_byte + 8'd1);
    end else if ({1'b0, byte_position} + 3'd1 < size) begin
      partial_pixel_next = {partial_pixel[15:0], data_byte};
      byte_position_next = byte_position + 2'd1;
    end else begin
      res.done           = 1'b1;
      byte_position_next = 2'd0;
      partial_pixel_next = 24'd0;
      if (rle_on && packet_left != 8'd0) begin
        if (packet_is_run) begin
          res.rep          = packet_left;
          packet_left_next = 8'd0;
        end else begin
          packet_left_next = packet_left - 8'd1;
        end
      end
    end
    if (!take) begin
      res.done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      byte_position <= 2'd0;
      partial_pixel <= 24'd0;
    end else if (take) begin
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_position <= byte_position_next;
      partial_pixel <= partial_pixel_next;
    end
  end

endmodule

>>> sv/tgarle_cmap.sv
// colour map memory with entry conversion on load and registered lookup
// depends on tgarle_pkg
module tgarle_cmap #(
  parameter int MAP_ENTRIES = tgarle_pkg::MAP_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [31:0] wr_bytes,
  input  logic [1:0]  map_depth,
  input  logic        rd_en,
  input  logic [31:0] rd_pix,
  input  logic [15:0] map_start,
  output logic [31:0] rd_data,
  output logic        rd_hit
);
  import tgarle_pkg::*;

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  logic [31:0] colour_mem [MAP_ENTRIES];
  logic [31:0] entry;
  logic [15:0] c;
  logic [31:0] rgb;
  logic [31:0] idx;
  logic        wr_ok;

  assign c   = {wr_bytes[15:8], wr_bytes[7:0]};
  assign rgb = ({16'd0, c & MASK_RED} << 6) | ({16'd0, c & MASK_GREEN} << 3)
             | {16'd0, c & MASK_BLUE};

  always_comb begin
    case (map_depth)
      DEPTH_15: entry = rgb | ALPHA_OPAQUE;
      DEPTH_16: entry = rgb | (((c & MASK_ATTR) != 16'd0) ? ALPHA_OPAQUE : 32'd0);
      DEPTH_24: entry = ALPHA_OPAQUE | {8'd0, wr_bytes[7:0], wr_bytes[15:8], wr_bytes[23:16]};
      default:  entry = {wr_bytes[31:24], wr_bytes[7:0], wr_bytes[15:8], wr_bytes[23:16]};
    endcase
  end

  assign wr_ok = {24'd0, wr_index} < 32'(MAP_ENTRIES);
  assign idx   = rd_pix - {16'd0, map_start};

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      colour_mem[IDX_W'(wr_index)] <= entry;
    end
    if (rd_en) begin
      rd_data <= colour_mem[idx[IDX_W-1:0]];
      rd_hit  <= idx < 32'(MAP_ENTRIES);
    end
  end

endmodule

>>> sv/tga_rle_pixel_decoder.sv
// tga run-length pixel decoder: takes one beat per cycle on the feed channel, either a
// pixel-data byte or a colour map load, and delivers decoded 32-bit pixels with a repeat
// count on the result channel. a new beat is accepted every cycle while the result side
// keeps up; a completed pixel is registered in stage one, with its colour map read, and
// then in the output register before it reaches the result channel. the colour table
// is a memory with one write and one registered read port, so a map load followed at once
// by a pixel that reads it sees the new entry. entries never loaded read as undefined.
// the user must write configuration via the cfg channel while idle; nothing enforces it.
// depends on tgarle_pkg, tgarle_if, tgarle_assemble and tgarle_cmap
module tga_rle_pixel_decoder #(
  parameter int MAP_ENTRIES = tgarle_pkg::MAP_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tgarle_in_if.sink     feed,
  tgarle_out_if.source  result,
  tgarle_cfg_if.sink    cfg
);
  import tgarle_pkg::*;

  // configuration registers
  logic [1:0]  image_kind;
  logic        rle_on;
  logic [2:0]  pixel_bytes;
  logic [15:0] map_start;
  logic [1:0]  map_depth;

  // handshake
  logic take, byte_take, map_take;
  logic out_free, s1_go;

  asm_t        asm_res;

  // stage one: assembled pixel, colour map read in flight
  logic        s1_valid;
  logic [31:0] s1_pix;
  logic [7:0]  s1_rep;
  logic [1:0]  s1_kind;
  logic [31:0] map_data;
  logic        map_hit;

  // output register
  logic        o_valid;
  logic [31:0] o_pixel;
  logic [7:0]  o_rep;
  logic        o_bad;
  logic [31:0] final_pix;
  logic        final_bad;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_kind  <= KIND_TRUE;
      rle_on      <= 1'b0;
      pixel_bytes <= 3'd4;
      map_start   <= 16'd0;
      map_depth   <= DEPTH_32;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_KIND:  image_kind  <= cfg.data[1:0];
        REG_RLE_ON:      rle_on      <= cfg.data[0];
        REG_PIXEL_BYTES: pixel_bytes <= cfg.data[2:0];
        REG_MAP_START:   map_start   <= cfg.data;
        REG_MAP_DEPTH:   map_depth   <= cfg.data[1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // a beat is taken whenever stage one is empty or moves on this cycle
  assign out_free   = !o_valid || result.ready;
  assign s1_go      = s1_valid && out_free;
  assign feed.ready = !s1_valid || out_free;
  assign take       = feed.valid && feed.ready;
  assign byte_take  = take && !feed.action;
  assign map_take   = take && feed.action;

  tgarle_assemble u_assemble (
    .clk         (clk),
    .rst         (rst),
    .take        (byte_take),
    .data_byte   (feed.data_byte),
    .rle_on      (rle_on),
    .pixel_bytes (pixel_bytes),
    .res         (asm_res)
  );

  tgarle_cmap #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_cmap (
    .clk       (clk),
    .wr_en     (map_take),
    .wr_index  (feed.map_index),
    .wr_bytes  (feed.map_bytes),
    .map_depth (map_depth),
    .rd_en     (asm_res.done),
    .rd_pix    (asm_res.pix),
    .map_start (map_start),
    .rd_data   (map_data),
    .rd_hit    (map_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (asm_res.done) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (asm_res.done) begin
      s1_pix  <= asm_res.pix;
      s1_rep  <= asm_res.rep;
      s1_kind <= image_kind;
    end
  end

  // final colour selection by image kind
  always_comb begin
    final_bad = 1'b0;
    case (s1_kind)
      KIND_CMAP: begin
        final_bad = !map_hit;
        final_pix = map_hit ? map_data : 32'd0;
      end
      KIND_GREY: final_pix = {4{s1_pix[7:0]}};
      default:   final_pix = s1_pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_pixel <= final_pix;
      o_rep   <= s1_rep;
      o_bad   <= final_bad;
    end
  end

  assign result.valid      = o_valid;
  assign result.pixel      = o_pixel;
  assign result.repeat_res = o_rep;
  assign result.bad_index  = o_bad;

endmodule
